FILE: design/vwbp_pkg.sv
`default_nettype none

package vwbp_pkg;

   // Request and response packing.
   localparam int REQ_DATA_WIDTH  = 40;
   localparam int REQ_USER_WIDTH  = 2;
   localparam int RSP_DATA_WIDTH  = 24;
   localparam int RSP_USER_WIDTH  = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 11;

   // Field and state widths.
   localparam int VALUE_WIDTH   = 32;
   localparam int WIDTH_BITS    = 7;
   localparam int PENDING_WIDTH = 7;
   localparam int FILL_WIDTH    = 3;
   localparam int COUNT_WIDTH   = 11;
   localparam int INDEX_WIDTH   = 10;
   localparam int MERGE_WIDTH   = PENDING_WIDTH + VALUE_WIDTH;
   localparam int TOTAL_WIDTH   = 6;
   localparam int RESULT_WIDTH  = 3;

   // Capacity limits.
   localparam int CAPACITY_RESET       = 1024;
   localparam int MAX_MESSAGE_DEFAULT  = 1024;
   localparam int CAPACITY_FIELD_MAX   = (1 << COUNT_WIDTH) - 1;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

   // Action codes.
   localparam logic [1:0] ACTION_WRITE   = 2'd0;
   localparam logic [1:0] ACTION_ALIGN   = 2'd1;
   localparam logic [1:0] ACTION_RESTART = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAPACITY       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OVERFLOW_ALLOW = 2'd1;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_OVF_RESTART  = 3'd1,
      STATUS_OVF_REJECT   = 3'd2,
      STATUS_BAD_WIDTH    = 3'd3,
      STATUS_OUT_OF_RANGE = 3'd4
   } status_type;

   // One command for the back end: either a single status result or a run
   // of byte writes taken from the merged bit string.
   typedef struct packed {
      logic                     has_bytes;
      status_type               status;
      logic                     overflow;
      logic [INDEX_WIDTH-1:0]   start_index;
      logic [MERGE_WIDTH-1:0]   data;
      logic [TOTAL_WIDTH-1:0]   total_bits;
   } entry_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

FILE: design/vwbp_queue.sv
`default_nettype none

module vwbp_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  vwbp_pkg::entry_type        push_entry,
   input  wire                        pop,
   output vwbp_pkg::entry_type        head_entry,
   output vwbp_pkg::queue_status_type status
);
   import vwbp_pkg::*;

   entry_type                  slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH:0]   count_ff, count_in;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("Command queue written while full.");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("Command queue read while empty.");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH))
      else $error("Command queue occupancy out of range.");

endmodule

`default_nettype wire

FILE: design/vwbp_front.sv
`default_nettype none

module vwbp_front #(
   parameter int MAX_MESSAGE_BYTES = vwbp_pkg::MAX_MESSAGE_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    accept,
   input  wire  [1:0]                             action,
   input  wire  [vwbp_pkg::VALUE_WIDTH-1:0]       field_value,
   input  wire  [vwbp_pkg::WIDTH_BITS-1:0]        field_width,
   input  wire  [vwbp_pkg::COUNT_WIDTH-1:0]       capacity_bytes,
   input  wire                                    overflow_allowed,
   output vwbp_pkg::entry_type                    entry
);
   import vwbp_pkg::*;

   localparam int CapLimit = (MAX_MESSAGE_BYTES > CAPACITY_FIELD_MAX) ?
                             CAPACITY_FIELD_MAX : MAX_MESSAGE_BYTES;

   logic [PENDING_WIDTH-1:0] pending_ff, pending_in;
   logic [FILL_WIDTH-1:0]    fill_ff, fill_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                     overflow_ff, overflow_in;

   logic signed [WIDTH_BITS-1:0] width_s;
   logic [WIDTH_BITS-1:0]        magnitude;
   logic [5:0]                   n_bits;
   logic                         width_bad;
   logic [VALUE_WIDTH-1:0]       value_mask;
   logic [VALUE_WIDTH-1:0]       signed_mask;
   logic [VALUE_WIDTH-1:0]       upper_bits;
   logic                         range_ok;
   logic [COUNT_WIDTH-1:0]       cap_eff;
   logic [15:0]                  cap_bits;
   logic [15:0]                  need_bits;
   logic [MERGE_WIDTH-1:0]       merged;
   logic [TOTAL_WIDTH-1:0]       total;
   logic [MERGE_WIDTH-1:0]       shifted;

   // Width decode and value range check.
   always_comb begin
      width_s     = signed'(field_width);
      magnitude   = width_s[WIDTH_BITS-1] ? (~field_width + 1'b1) : field_width;
      n_bits      = magnitude[5:0];
      width_bad   = (width_s == 7'sd0) || (width_s < -7'sd31) || (width_s > 7'sd32);
      value_mask  = {VALUE_WIDTH{1'b1}} >> (6'd32 - n_bits);
      signed_mask = {VALUE_WIDTH{1'b1}} >> (6'd33 - n_bits);
      if (width_s[WIDTH_BITS-1]) begin
         upper_bits = field_value & ~signed_mask;
         range_ok   = (upper_bits == '0) || (upper_bits == ~signed_mask);
      end else begin
         upper_bits = field_value & ~value_mask;
         range_ok   = (upper_bits == '0);
      end
   end

   // Capacity check and merge of the new bits above the pending ones.
   always_comb begin
      cap_eff   = (capacity_bytes > COUNT_WIDTH'(CapLimit)) ?
                  COUNT_WIDTH'(CapLimit) : capacity_bytes;
      cap_bits  = {2'b00, cap_eff, 3'b000};
      need_bits = {2'b00, count_ff, 3'b000} + 16'(fill_ff) + 16'(n_bits);
      merged    = MERGE_WIDTH'(pending_ff) |
                  (MERGE_WIDTH'(field_value & value_mask) << fill_ff);
      total     = TOTAL_WIDTH'(fill_ff) + n_bits;
      shifted   = merged >> {total[5:3], 3'b000};
   end

   // Next state and command for the back end.
   always_comb begin
      pending_in        = pending_ff;
      fill_in           = fill_ff;
      count_in          = count_ff;
      overflow_in       = overflow_ff;
      entry.has_bytes   = 1'b0;
      entry.status      = STATUS_OK;
      entry.start_index = count_ff[INDEX_WIDTH-1:0];
      entry.data        = merged;
      entry.total_bits  = total;
      case (action)
         ACTION_WRITE: begin
            if (width_bad) begin
               entry.status = STATUS_BAD_WIDTH;
            end else if (!range_ok) begin
               entry.status = STATUS_OUT_OF_RANGE;
            end else if (need_bits > cap_bits) begin
               if (!overflow_allowed || (16'(n_bits) > cap_bits)) begin
                  entry.status = STATUS_OVF_REJECT;
               end else begin
                  entry.status = STATUS_OVF_RESTART;
                  pending_in   = '0;
                  fill_in      = '0;
                  count_in     = '0;
                  overflow_in  = 1'b1;
               end
            end else begin
               entry.has_bytes = 1'b1;
               pending_in      = shifted[PENDING_WIDTH-1:0];
               fill_in         = total[2:0];
               count_in        = count_ff + COUNT_WIDTH'(total[5:3]);
            end
         end
         ACTION_ALIGN: begin
            if (fill_ff != '0) begin
               count_in = count_ff + 1'b1;
            end
            pending_in = '0;
            fill_in    = '0;
         end
         ACTION_RESTART: begin
            pending_in  = '0;
            fill_in     = '0;
            count_in    = '0;
            overflow_in = 1'b0;
         end
         default: begin
         end
      endcase
      entry.overflow = overflow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         fill_ff     <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (accept) begin
         pending_ff  <= pending_in;
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/vwbp_back.sv
`default_nettype none

module vwbp_back (
   input  wire                                   clock,
   input  wire                                   reset,
   input  vwbp_pkg::entry_type                   head_entry,
   input  vwbp_pkg::queue_status_type            queue_status,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [vwbp_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic [vwbp_pkg::RSP_USER_WIDTH-1:0]   rsp_tuser,
   output logic                                  rsp_tlast
);
   import vwbp_pkg::*;

   logic [RESULT_WIDTH-1:0] step_ff, step_in;
   logic                    valid_ff, valid_in;
   logic                    byte_valid_ff, byte_valid_in;
   logic [INDEX_WIDTH-1:0]  index_ff, index_in;
   logic [7:0]              data_ff, data_in;
   logic                    partial_ff, partial_in;
   status_type              status_ff, status_in;
   logic                    overflow_ff, overflow_in;
   logic                    last_ff, last_in;

   logic                    advance;
   logic [RESULT_WIDTH-1:0] full_bytes;
   logic                    has_tail;
   logic [RESULT_WIDTH-1:0] last_step;
   logic [MERGE_WIDTH-1:0]  byte_window;

   // Walk the head command one result per cycle while the response is not stalled.
   always_comb begin
      advance       = !valid_ff || rsp_tready;
      full_bytes    = head_entry.total_bits[5:3];
      has_tail      = |head_entry.total_bits[2:0];
      last_step     = full_bytes + RESULT_WIDTH'(has_tail) - 1'b1;
      byte_window   = head_entry.data >> {step_ff, 3'b000};
      step_in       = step_ff;
      pop           = 1'b0;
      valid_in      = valid_ff;
      byte_valid_in = byte_valid_ff;
      index_in      = index_ff;
      data_in       = data_ff;
      partial_in    = partial_ff;
      status_in     = status_ff;
      overflow_in   = overflow_ff;
      last_in       = last_ff;
      if (advance) begin
         valid_in = !queue_status.empty;
         if (!queue_status.empty) begin
            status_in   = head_entry.status;
            overflow_in = head_entry.overflow;
            if (head_entry.has_bytes) begin
               byte_valid_in = 1'b1;
               index_in      = head_entry.start_index + INDEX_WIDTH'(step_ff);
               data_in       = byte_window[7:0];
               partial_in    = (step_ff == full_bytes);
               last_in       = (step_ff == last_step);
            end else begin
               byte_valid_in = 1'b0;
               index_in      = '0;
               data_in       = '0;
               partial_in    = 1'b0;
               last_in       = 1'b1;
            end
            if (last_in) begin
               pop     = 1'b1;
               step_in = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_valid_ff <= byte_valid_in;
      index_ff      <= index_in;
      data_ff       <= data_in;
      partial_ff    <= partial_in;
      status_ff     <= status_in;
      overflow_ff   <= overflow_in;
      last_ff       <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, overflow_ff, partial_ff, data_ff, index_ff};
   assign rsp_tuser  = {status_ff, byte_valid_ff};
   assign rsp_tlast  = last_ff;

   a_idle_result_clear: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !byte_valid_ff) |-> (index_ff == '0 && data_ff == '0 && !partial_ff))
      else $error("Status-only result carries byte fields.");

   a_partial_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && partial_ff) |-> last_ff)
      else $error("Partial byte is not the final result of its transaction.");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff != STATUS_OK) |-> (last_ff && !byte_valid_ff))
      else $error("Error status not given as a single result.");

   a_step_reset_on_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> (step_ff == '0))
      else $error("Result counter not cleared after a command completed.");

endmodule

`default_nettype wire

FILE: design/variable_width_bit_packer.sv
// LSB-first bit stream writer. Each request transaction either writes a field
// of 1 to 32 bits (a negative width marks a signed field), byte-aligns, or
// restarts the message; tuser selects which. A write is checked for width,
// value range and remaining capacity, then its bits are merged above the
// pending bits and the block answers with one byte write per completed byte
// plus a rewrite of the trailing partial byte, tlast on the final one. Any
// rejected or non-write request answers with one status-only response. The
// front end decodes a request combinationally and queues a command; the back end
// drains commands through the single response register at one response per
// cycle while the response is not stalled, so a request yields 1 to 5 responses,
// and the four-entry queue lets requests be taken while responses back up.
// Configuration writes are taken on any cycle but must only be issued while
// the block is idle.
`default_nettype none

module variable_width_bit_packer #(
   parameter int MAX_MESSAGE_BYTES = vwbp_pkg::MAX_MESSAGE_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // Request stream.
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   // tdata: field_value[31:0], field_width[38:32], zero [39].
   input  wire  [vwbp_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   // tuser: action[1:0].
   input  wire  [vwbp_pkg::REQ_USER_WIDTH-1:0]    req_tuser,
   // Response stream.
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   // tdata: byte_index[9:0], byte_data[17:10], partial_byte[18],
   // overflow_seen[19], zero [23:20].
   output logic [vwbp_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   // tuser: byte_valid[0], status[3:1].
   output logic [vwbp_pkg::RSP_USER_WIDTH-1:0]    rsp_tuser,
   output logic                                   rsp_tlast,
   // Configuration write channel.
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [vwbp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire  [vwbp_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import vwbp_pkg::*;

   logic [COUNT_WIDTH-1:0] capacity_ff, capacity_in;
   logic                   allow_ff, allow_in;
   logic                   req_accept;
   logic                   pop;
   entry_type              push_entry;
   entry_type              head_entry;
   queue_status_type       queue_status;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      allow_in    = allow_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CAPACITY:       capacity_in = csr_data;
            CSR_OVERFLOW_ALLOW: allow_in    = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= COUNT_WIDTH'(CAPACITY_RESET);
         allow_ff    <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         allow_ff    <= allow_in;
      end
   end

   // Requests are taken whenever the command queue has room.
   assign req_tready = !queue_status.full;
   assign req_accept = req_tvalid && req_tready;

   vwbp_front #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .action           (req_tuser),
      .field_value      (req_tdata[VALUE_WIDTH-1:0]),
      .field_width      (req_tdata[VALUE_WIDTH+WIDTH_BITS-1:VALUE_WIDTH]),
      .capacity_bytes   (capacity_ff),
      .overflow_allowed (allow_ff),
      .entry            (push_entry)
   );

   vwbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   vwbp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_variable_width_bit_packer.sv
`default_nettype none

module tb_variable_width_bit_packer;
   timeunit 1ns;
   timeprecision 1ps;

   import vwbp_pkg::*;

   // Codes the package leaves unnamed: the spare action and a spare register slot.
   localparam logic [1:0] ACTION_SPARE = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;
   localparam int IDLE_PERCENT = 36;
   localparam int STALL_LENGTH = 90;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] value;
      logic [6:0]  width;
   } field_req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [9:0] byte_index;
      logic [7:0] byte_data;
      logic       partial;
      status_type status;
      logic       overflow_seen;
      logic       last;
   } byte_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [REQ_USER_WIDTH-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [RSP_USER_WIDTH-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   // Shadow of the packer: configuration and message state.
   logic [10:0] capacity_shadow;
   logic        overflow_allow_shadow;
   logic [63:0] pending_shadow;
   int          fill_shadow;
   logic [10:0] byte_count_shadow;
   logic        overflow_flag_shadow;

   field_req_type  fields_to_send[$];
   byte_write_type byte_writes_due[$];
   logic        req_taken = 1'b0;
   int          requests_taken = 0;
   int          responses_seen = 0;
   int          mismatch_count = 0;
   int          status_tally[5] = '{default: 0};
   int          byte_write_count = 0;
   int          hold_cycles = 0;
   logic        long_stall_done = 1'b0;
   logic        no_idle;

   variable_width_bit_packer u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // A window in the middle of the run where neither side idles at random.
   assign no_idle = (requests_taken >= 120) && (requests_taken < 165);

   function automatic void clear_message();
      pending_shadow = '0;
      fill_shadow = 0;
      byte_count_shadow = '0;
      overflow_flag_shadow = 1'b0;
   endfunction

   function automatic void expect_write(logic valid, logic [9:0] idx, logic [7:0] data,
                                        logic part, status_type st, logic is_last);
      byte_write_type w;
      w.byte_valid = valid;
      w.byte_index = idx;
      w.byte_data = data;
      w.partial = part;
      w.status = st;
      w.overflow_seen = overflow_flag_shadow;
      w.last = is_last;
      byte_writes_due.push_back(w);
      status_tally[int'(st)]++;
      if (valid) byte_write_count++;
   endfunction

   // Work out the response transactions that one accepted request causes.
   function automatic void pack_request(logic [1:0] act, logic [31:0] raw, logic [6:0] wraw);
      int     w;
      int     n;
      int     total;
      int     k;
      longint v;
      longint lim;
      longint cap_bits;
      longint room;
      w = $signed(wraw);
      v = $signed(raw);
      if (act == ACTION_ALIGN) begin
         if (fill_shadow != 0) byte_count_shadow = byte_count_shadow + 11'd1;
         fill_shadow = 0;
         pending_shadow = '0;
         expect_write(1'b0, '0, '0, 1'b0, STATUS_OK, 1'b1);
         return;
      end
      if (act == ACTION_RESTART) begin
         clear_message();
         expect_write(1'b0, '0, '0, 1'b0, STATUS_OK, 1'b1);
         return;
      end
      if (act == ACTION_SPARE) begin
         expect_write(1'b0, '0, '0, 1'b0, STATUS_OK, 1'b1);
         return;
      end
      if (w == 0 || w < -31 || w > 32) begin
         expect_write(1'b0, '0, '0, 1'b0, STATUS_BAD_WIDTH, 1'b1);
         return;
      end
      // Range check against the field width, signed or unsigned.
      if (w > 0 && w < 32) begin
         if (v < 0 || v > (longint'(1) << w) - 1) begin
            expect_write(1'b0, '0, '0, 1'b0, STATUS_OUT_OF_RANGE, 1'b1);
            return;
         end
      end else if (w < 0) begin
         lim = longint'(1) << (-1 - w);
         if (v > lim - 1 || v < -lim) begin
            expect_write(1'b0, '0, '0, 1'b0, STATUS_OUT_OF_RANGE, 1'b1);
            return;
         end
      end
      n = (w < 0) ? -w : w;
      // Capacity check; a capacity above the maximum acts as the maximum.
      cap_bits = (capacity_shadow > MAX_MESSAGE_DEFAULT) ? MAX_MESSAGE_DEFAULT : capacity_shadow;
      cap_bits = cap_bits * 8;
      room = cap_bits - (longint'(byte_count_shadow) * 8 + fill_shadow);
      if (n > room) begin
         if (!overflow_allow_shadow || n > cap_bits) begin
            expect_write(1'b0, '0, '0, 1'b0, STATUS_OVF_REJECT, 1'b1);
         end else begin
            clear_message();
            overflow_flag_shadow = 1'b1;
            expect_write(1'b0, '0, '0, 1'b0, STATUS_OVF_RESTART, 1'b1);
         end
         return;
      end
      // Merge above the pending bits, then emit full bytes and the partial one.
      pending_shadow = pending_shadow |
                       ((64'(raw) & ((64'd1 << n) - 64'd1)) << fill_shadow);
      fill_shadow = fill_shadow + n;
      total = fill_shadow / 8 + ((fill_shadow % 8) != 0 ? 1 : 0);
      k = 0;
      while (fill_shadow >= 8) begin
         expect_write(1'b1, byte_count_shadow[9:0], pending_shadow[7:0], 1'b0, STATUS_OK,
                      k == total - 1);
         k++;
         byte_count_shadow = byte_count_shadow + 11'd1;
         pending_shadow = pending_shadow >> 8;
         fill_shadow = fill_shadow - 8;
      end
      if (fill_shadow > 0)
         expect_write(1'b1, byte_count_shadow[9:0], pending_shadow[7:0], 1'b1, STATUS_OK,
                      1'b1);
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   // Request capture and prediction, then response checking, on the rising edge.
   always @(posedge clock) begin
      byte_write_type got;
      byte_write_type want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         pack_request(req_tuser, req_tdata[31:0], req_tdata[38:32]);
         requests_taken++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         got.byte_valid = rsp_tuser[0];
         got.status = status_type'(rsp_tuser[3:1]);
         got.byte_index = rsp_tdata[9:0];
         got.byte_data = rsp_tdata[17:10];
         got.partial = rsp_tdata[18];
         got.overflow_seen = rsp_tdata[19];
         got.last = rsp_tlast;
         if (byte_writes_due.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0h", $time, got);
            mismatch_count++;
         end else begin
            want = byte_writes_due.pop_front();
            check_field("byte_valid", want.byte_valid, got.byte_valid);
            check_field("byte_index", want.byte_index, got.byte_index);
            check_field("byte_data", want.byte_data, got.byte_data);
            check_field("partial_byte", want.partial, got.partial);
            check_field("status", want.status, got.status);
            check_field("overflow_seen", want.overflow_seen, got.overflow_seen);
            check_field("last", want.last, got.last);
         end
      end
   end

   // Request driver: hold an offered transaction until it is taken.
   always @(negedge clock) begin
      field_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (fields_to_send.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
            nxt = fields_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {1'b0, nxt.width, nxt.value};
            req_tuser <= nxt.action;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response backpressure, with one long hold-off so the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!long_stall_done && requests_taken >= 70) begin
            hold_cycles = STALL_LENGTH;
            long_stall_done = 1'b1;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   function automatic void queue_field(logic [1:0] act, logic [31:0] value, int w);
      field_req_type r;
      r.action = act;
      r.value = value;
      r.width = w[6:0];
      fields_to_send.push_back(r);
   endfunction

   // Mostly well-formed writes with random content, plus aligns, restarts and noise.
   function automatic void queue_random_field();
      int          p;
      int          q;
      int          n;
      logic [31:0] r;
      p = $urandom_range(99);
      if (p >= 96) begin
         queue_field(ACTION_SPARE, $urandom, $urandom_range(127));
      end else if (p >= 90) begin
         queue_field(ACTION_RESTART, $urandom, $urandom_range(127));
      end else if (p >= 78) begin
         queue_field(ACTION_ALIGN, $urandom, $urandom_range(127));
      end else begin
         q = $urandom_range(99);
         if (q < 6) begin
            case ($urandom_range(2))
               0: queue_field(ACTION_WRITE, $urandom, 0);
               1: queue_field(ACTION_WRITE, $urandom, $urandom_range(63, 33));
               default: queue_field(ACTION_WRITE, $urandom, -int'($urandom_range(64, 32)));
            endcase
         end else begin
            n = $urandom_range(32, 1);
            r = $urandom;
            if (q < 88) begin
               if (n < 32 && $urandom_range(1)) begin
                  // In range for a signed field: sign-extend the low n bits.
                  r = $unsigned($signed(r << (32 - n)) >>> (32 - n));
                  queue_field(ACTION_WRITE, r, -n);
               end else begin
                  if (n < 32) r = r & ((32'd1 << n) - 32'd1);
                  queue_field(ACTION_WRITE, r, n);
               end
            end else begin
               queue_field(ACTION_WRITE, r, ($urandom_range(1) && n < 32) ? -n : n);
            end
         end
      end
   endfunction

   task automatic wait_until_idle();
      do @(negedge clock);
      while (fields_to_send.size() != 0 || req_tvalid || byte_writes_due.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [10:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_CAPACITY) capacity_shadow = value;
      else if (idx == CSR_OVERFLOW_ALLOW) overflow_allow_shadow = value[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(logic [10:0] capacity, logic allow, int count);
      wait_until_idle();
      write_register(CSR_CAPACITY, capacity);
      write_register(CSR_OVERFLOW_ALLOW, allow);
      repeat (count) queue_random_field();
   endtask

   // Stimulus sequence.
   initial begin
      capacity_shadow = 11'(CAPACITY_RESET);
      overflow_allow_shadow = 1'b0;
      clear_message();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, bad widths, range failures, every action.
      queue_field(ACTION_WRITE, 32'h0000_0001, 1);
      queue_field(ACTION_WRITE, 32'hFFFF_FFFF, 32);
      queue_field(ACTION_WRITE, 32'hC000_0000, -31);
      queue_field(ACTION_WRITE, 32'h3FFF_FFFF, -31);
      queue_field(ACTION_WRITE, 32'hFFFF_FFFF, -1);
      queue_field(ACTION_WRITE, 32'h0000_0000, -1);
      queue_field(ACTION_WRITE, 32'h7FFF_FFFF, 31);
      queue_field(ACTION_WRITE, $urandom, 0);
      queue_field(ACTION_WRITE, $urandom, 33);
      queue_field(ACTION_WRITE, $urandom, -32);
      queue_field(ACTION_WRITE, $urandom, 63);
      queue_field(ACTION_WRITE, $urandom, -64);
      queue_field(ACTION_WRITE, 32'h0000_0100, 8);
      queue_field(ACTION_WRITE, 32'hFFFF_FFFF, 5);
      queue_field(ACTION_WRITE, 32'h0000_0080, -8);
      queue_field(ACTION_WRITE, 32'hFFFF_FF7F, -8);
      queue_field(ACTION_ALIGN, '0, 0);
      queue_field(ACTION_ALIGN, '0, 0);
      queue_field(ACTION_WRITE, 32'h0000_0000, 32);
      queue_field(ACTION_WRITE, 32'h0000_0055, 7);
      queue_field(ACTION_SPARE, 32'hFFFF_FFFF, -1);
      queue_field(ACTION_RESTART, '0, 0);

      // Directed overflow: reject, restart with the sticky flag, oversized field.
      wait_until_idle();
      write_register(CSR_CAPACITY, 11'd1);
      queue_field(ACTION_WRITE, 32'h0000_00A5, 8);
      queue_field(ACTION_WRITE, 32'h0000_0001, 1);
      wait_until_idle();
      write_register(CSR_OVERFLOW_ALLOW, 1'b1);
      queue_field(ACTION_WRITE, 32'h0000_0000, 1);
      queue_field(ACTION_WRITE, 32'h0000_0100, 9);
      queue_field(ACTION_RESTART, '0, 0);
      wait_until_idle();
      write_register(CSR_CAPACITY, 11'd0);
      queue_field(ACTION_WRITE, 32'h0000_0001, 1);

      // Random phases across capacity and overflow settings.
      run_random_phase(11'd1024, 1'b0, 30);
      run_random_phase(11'd4, 1'b0, 30);
      run_random_phase(11'd4, 1'b1, 30);
      run_random_phase(11'd2047, 1'b1, 30);
      run_random_phase(11'd2, 1'b1, 30);
      run_random_phase(11'd1, 1'b0, 28);
      wait_until_idle();
      write_register(CSR_SPARE, 11'(($urandom)));
      write_register(CSR_CAPACITY, 11'd16);
      queue_random_field();
      queue_random_field();

      // Drain, then give any stray response time to show up.
      do @(negedge clock);
      while (fields_to_send.size() != 0 || req_tvalid || byte_writes_due.size() != 0);
      repeat (20) @(posedge clock);
      if (byte_writes_due.size() != 0) begin
         $display("%0t: %0d responses still expected at the end", $time, byte_writes_due.size());
         mismatch_count++;
      end
      $display("Run covered %0d request and %0d response transactions, %0d byte writes.",
               requests_taken, responses_seen, byte_write_count);
      $display({"Statuses: ok %0d, overflow restart %0d, overflow reject %0d, ",
                "bad width %0d, range %0d."},
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4]);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
